>>> hw/rtl/smtb_pkg.sv
package smtb_pkg;

  localparam int LOD_LEVELS  = 4;
  localparam int TABLE_DEPTH = 1024;

  localparam int SLOTS  = LOD_LEVELS * TABLE_DEPTH;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LOD_AW = (LOD_LEVELS > 1) ? $clog2(LOD_LEVELS) : 1;

  localparam int KIND_W  = 2;
  localparam int LOD_W   = 3;
  localparam int IDX_W   = 10;
  localparam int VID_W   = 16;
  localparam int POS_W   = 24;
  localparam int CNT_W   = 11;
  localparam int WGT_W   = 16;

  localparam int IN_DATA_W  = 104;
  localparam int IN_USER_W  = KIND_W + LOD_W;
  localparam int OUT_DATA_W = 3 * POS_W;
  localparam int OUT_USER_W = 1;

  localparam logic [WGT_W-1:0] WEIGHT_ONE = 16'h8000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [VID_W-1:0]        id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } entry_t;

  function automatic logic signed [POS_W-1:0] blend(
    input logic signed [POS_W-1:0] src,
    input logic signed [POS_W-1:0] tgt,
    input logic [WGT_W-1:0]        w
  );
    logic [WGT_W-1:0]            inv;
    logic signed [POS_W+WGT_W:0] p_src;
    logic signed [POS_W+WGT_W:0] p_tgt;
    logic signed [POS_W+WGT_W+1:0] sum;
    inv   = WEIGHT_ONE - w;
    p_src = src * $signed({1'b0, inv});
    p_tgt = tgt * $signed({1'b0, w});
    sum   = (POS_W+WGT_W+2)'(p_src) + (POS_W+WGT_W+2)'(p_tgt)
          + (POS_W+WGT_W+2)'(16384);
    return sum[POS_W+14:15];
  endfunction

endpackage

>>> hw/rtl/sparse_morph_target_blend.sv
// Channel | Signals                                   | Transfer
// in      | in_tvalid in_tready in_tdata in_tuser in_tlast | tvalid & tready
// out     | out_tvalid out_tready out_tdata out_tuser out_tlast | tvalid & tready
// cfg     | cfg_valid cfg_ready cfg_data              | valid & ready (ready tied high)
//
// One item per cycle unless out stalls; a result passes stage and output registers.
// Loads write the table and clears zero the count at transfer; neither gives a result.
// The table read address depends on the vertex ahead in the stage register, through
// the match compares and an increment feeding the synchronous table memory.
// rst_n clears counts, walk state, weight and valid flags; the table is not cleared.
// A stalled output holds the stage register, which holds the input.
module sparse_morph_target_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_index[9:0], vertex_id[25:10], pos_x[49:26], pos_y[73:50], pos_z[97:74]
  input  logic [smtb_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind[1:0], lod[4:2]
  input  logic [smtb_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_x[23:0], out_y[47:24], out_z[71:48]
  output logic [smtb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // morphed[0]
  output logic [smtb_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smtb_pkg::WGT_W-1:0]         cfg_data
);
  import smtb_pkg::*;

  logic [KIND_W-1:0]       in_kind;
  logic [LOD_W-1:0]        in_lod;
  logic [IDX_W-1:0]        in_idx;
  logic [VID_W-1:0]        in_vid;
  logic signed [POS_W-1:0] in_x;
  logic signed [POS_W-1:0] in_y;
  logic signed [POS_W-1:0] in_z;
  logic                    in_acc;
  logic                    in_lod_ok;

  entry_t                  mem [SLOTS];
  entry_t                  ent_r;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr;

  logic [CNT_W-1:0]        cnt_r [LOD_LEVELS];
  logic [WGT_W-1:0]        weight_r;
  logic [CNT_W-1:0]        ne_r;
  logic [CNT_W-1:0]        ne_nxt;
  logic [VID_W-1:0]        vpos_r;
  logic [VID_W-1:0]        vpos_nxt;

  logic                    stg_v_r;
  logic                    stg_v_nxt;
  logic                    stg_lod_ok_r;
  logic [CNT_W-1:0]        stg_cnt_r;
  logic signed [POS_W-1:0] stg_x_r;
  logic signed [POS_W-1:0] stg_y_r;
  logic signed [POS_W-1:0] stg_z_r;
  logic                    stg_last_r;
  logic                    stg_adv;
  logic                    match;
  logic [WGT_W-1:0]        w_sat;
  logic [CNT_W-1:0]        rd_ne;

  logic                    out_v_r;
  logic                    out_v_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_morph_r;
  logic                    out_last_r;

  assign in_kind   = in_tuser[KIND_W-1:0];
  assign in_lod    = in_tuser[KIND_W+LOD_W-1:KIND_W];
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_vid    = in_tdata[IDX_W+VID_W-1:IDX_W];
  assign in_x      = in_tdata[IDX_W+VID_W+POS_W-1:IDX_W+VID_W];
  assign in_y      = in_tdata[IDX_W+VID_W+2*POS_W-1:IDX_W+VID_W+POS_W];
  assign in_z      = in_tdata[IDX_W+VID_W+3*POS_W-1:IDX_W+VID_W+2*POS_W];
  assign in_lod_ok = 32'(in_lod) < LOD_LEVELS;

  assign stg_adv   = !out_v_r || out_tready;
  assign in_tready = !stg_v_r || stg_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign match = stg_lod_ok_r && (ne_r < stg_cnt_r) && (ent_r.id == vpos_r);
  assign w_sat = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;

  always_comb begin
    if (stg_last_r) begin
      ne_nxt   = '0;
      vpos_nxt = '0;
    end else begin
      ne_nxt   = match ? ne_r + CNT_W'(1) : ne_r;
      vpos_nxt = vpos_r + VID_W'(1);
    end
  end

  assign rd_ne   = stg_v_r ? ne_nxt : ne_r;
  assign wr_en   = in_acc && (in_kind == KIND_LOAD) && in_lod_ok
                && (32'(in_idx) < TABLE_DEPTH);
  assign wr_addr = in_lod_ok
                 ? ADDR_W'(in_lod) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(in_idx) : '0;
  assign rd_addr = in_lod_ok
                 ? ADDR_W'(in_lod) * ADDR_W'(TABLE_DEPTH) + ADDR_W'(rd_ne) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{id: in_vid, x: in_x, y: in_y, z: in_z};
    end
    if (in_acc) begin
      ent_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOD_LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (in_acc && in_lod_ok) begin
      case (in_kind)
        KIND_LOAD: begin
          if (32'(in_idx) < TABLE_DEPTH) begin
            cnt_r[in_lod[LOD_AW-1:0]] <= CNT_W'(in_idx) + CNT_W'(1);
          end
        end
        KIND_CLEAR: begin
          cnt_r[in_lod[LOD_AW-1:0]] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      weight_r <= cfg_data;
    end
  end

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_acc) begin
      stg_v_nxt = in_kind == KIND_VERTEX;
    end else if (stg_adv) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      ne_r    <= '0;
      vpos_r  <= '0;
    end else begin
      stg_v_r <= stg_v_nxt;
      if (stg_v_r && stg_adv) begin
        ne_r   <= ne_nxt;
        vpos_r <= vpos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_lod_ok_r <= in_lod_ok;
      stg_cnt_r    <= in_lod_ok ? cnt_r[in_lod[LOD_AW-1:0]] : '0;
      stg_x_r      <= in_x;
      stg_y_r      <= in_y;
      stg_z_r      <= in_z;
      stg_last_r   <= in_tlast;
    end
  end

  assign out_v_nxt = stg_adv ? stg_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && stg_v_r) begin
      if (match) begin
        out_data_r <= {blend(stg_z_r, ent_r.z, w_sat), blend(stg_y_r, ent_r.y, w_sat),
                       blend(stg_x_r, ent_r.x, w_sat)};
      end else begin
        out_data_r <= {stg_z_r, stg_y_r, stg_x_r};
      end
      out_morph_r <= match;
      out_last_r  <= stg_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_morph_r;
  assign out_tlast  = out_last_r;

  a_ne_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ne_r) <= TABLE_DEPTH)
    else $error("entry pointer beyond table depth");

  a_walk_reset: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && stg_adv && stg_last_r |=> ne_r == '0 && vpos_r == '0)
    else $error("walk not returned to start after last vertex");

  a_ne_step: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && stg_adv && match && !stg_last_r |=> ne_r == $past(ne_r) + CNT_W'(1))
    else $error("entry pointer did not advance after blend");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && !stg_adv |-> !in_tready)
    else $error("input taken while stage is blocked");

  a_morph_valid: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && stg_adv |=> out_tvalid && out_tuser[0] == $past(match))
    else $error("result flag does not follow stage match");

endmodule
